@@ rtl/core/swo_pkg.sv @@
// Package for the stereo wavetable oscillator: field widths, sample and
// weight types, reset and pitch constants, command codes.
// No dependencies.
package swo_pkg;

    localparam int KNOB_W      = 12;
    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 12;
    localparam int PHASE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int WEIGHT_W    = FRAC_W + 1;
    localparam int LOAD_WAVE_W = 6;
    localparam int LOAD_POS_W  = 10;

    typedef logic [KNOB_W-1:0]          knob_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0]    out_sample_t;
    typedef logic [WEIGHT_W-1:0]        weight_t;
    typedef logic [PHASE_W-1:0]         phase_t;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam phase_t              BASE_INC_RESET = 32'd39370534;
    localparam logic [FRAC_W-1:0]   OCT_SLOPE      = 16'd45426;
    localparam int                  KNOB_MAX       = 4095;
    localparam weight_t             WEIGHT_ONE     = 17'h10000;

endpackage

@@ rtl/core/swo_if.sv @@
// Channel interfaces of the oscillator: command items, result items and
// the base increment write channel.
// Depends on swo_pkg.
interface swo_cmd_if;
    import swo_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    knob_t                  pitch_knob;
    knob_t                  morph_knob;
    logic [LOAD_WAVE_W-1:0] load_wave;
    logic [LOAD_POS_W-1:0]  load_position;
    sample_t                load_value;

    modport source (
        output valid, mode, pitch_knob, morph_knob, load_wave, load_position, load_value,
        input  ready
    );
    modport sink (
        input  valid, mode, pitch_knob, morph_knob, load_wave, load_position, load_value,
        output ready
    );
endinterface

interface swo_result_if;
    import swo_pkg::*;

    logic        valid;
    logic        ready;
    out_sample_t forward_out;
    out_sample_t reverse_out;

    modport source (output valid, forward_out, reverse_out, input ready);
    modport sink   (input valid, forward_out, reverse_out, output ready);
endinterface

interface swo_cfg_if;
    import swo_pkg::*;

    logic   valid;
    logic   ready;
    phase_t base_increment;

    modport source (output valid, base_increment, input ready);
    modport sink   (input valid, base_increment, output ready);
endinterface

@@ rtl/core/swo_wave_mem.sv @@
// Wave table storage: one write port, one read port, registered read data.
// Depends on swo_pkg.
module swo_wave_mem #(
    parameter int DEPTH = 36000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  swo_pkg::sample_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output swo_pkg::sample_t rdata
);
    import swo_pkg::*;

    sample_t mem [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/swo_blend.sv @@
// Two-stage linear blend: floor((b*w + a*(65536-w)) / 2^16), w in 0..65536.
// New operands every cycle, result through prod_reg then res_reg. Depends on swo_pkg.
module swo_blend (
    input  logic              clk,
    input  swo_pkg::sample_t  a,
    input  swo_pkg::sample_t  b,
    input  swo_pkg::weight_t  w,
    output swo_pkg::sample_t  res
);
    import swo_pkg::*;

    localparam int PROD_W = SAMPLE_W + WEIGHT_W + 2;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [WEIGHT_W:0]   w_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    sum;

    sample_t                    a_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    sample_t                    res_reg;

    always_comb
    begin
        diff = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
        w_s  = {1'b0, w};
        prod = PROD_W'(diff * w_s);
        sum  = {{(SUM_W-SAMPLE_W-FRAC_W){a_reg[SAMPLE_W-1]}}, a_reg, {FRAC_W{1'b0}}}
             + {prod_reg[PROD_W-1], prod_reg};
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a;
        prod_reg <= prod;
        res_reg  <= sum[FRAC_W +: SAMPLE_W];
    end

    assign res = res_reg;

endmodule

@@ rtl/core/swo_incr.sv @@
// Phase increment from the pitch knob: whole-octave shift of the base
// increment plus a linear fractional-octave term. Pipelined through
// shift_reg/slope_reg, shift2_reg/adj_reg and inc_reg. Depends on swo_pkg.
module swo_incr (
    input  logic            clk,
    input  swo_pkg::knob_t  pitch,
    input  swo_pkg::phase_t base_inc,
    output swo_pkg::phase_t inc
);
    import swo_pkg::*;

    logic [2:0]          oct_code;
    logic [FRAC_W-1:0]   oct_frac;
    logic [2:0]          rshift;
    phase_t              shifted;
    logic [2*PHASE_W-1:0] prod;

    phase_t shift_reg;
    phase_t slope_reg;
    phase_t shift2_reg;
    phase_t adj_reg;
    phase_t inc_reg;

    always_comb
    begin
        oct_code = pitch[KNOB_W-1 -: 3];
        oct_frac = {pitch[KNOB_W-4:0], 7'b0};
        rshift   = 3'd4 - {1'b0, oct_code[1:0]};
        if (oct_code[2])
        begin
            shifted = base_inc << oct_code[1:0];
        end
        else
        begin
            shifted = base_inc >> rshift;
        end
        prod = {{PHASE_W{1'b0}}, shift_reg} * {{PHASE_W{1'b0}}, slope_reg};
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shifted;
        slope_reg  <= {{FRAC_W{1'b0}}, oct_frac} * {{FRAC_W{1'b0}}, OCT_SLOPE};
        shift2_reg <= shift_reg;
        adj_reg    <= prod[2*PHASE_W-1:PHASE_W];
        inc_reg    <= shift2_reg + adj_reg;
    end

    assign inc = inc_reg;

endmodule

@@ rtl/core/stereo_wavetable_oscillator_unit.sv @@
// Top level of the stereo wavetable oscillator: sequencer, phase and
// knob arithmetic, table reads, output register, checks.
// Depends on swo_pkg, swo_if, swo_wave_mem, swo_blend, swo_incr.

// Load items write one signed sample into the wave table (out-of-range
// wave or position is dropped, no result); table entries are undefined
// until loaded. A tick item reads eight table entries at the current
// phase and mirrored phase across the two waves picked by the morph knob,
// blends them into a forward and a reverse 12-bit sample, delivers one
// result and advances the phase by the pitch-scaled base increment.
// One item is in flight at a time: a tick runs through the setup states
// S_T0 to S_T3, then S_RUN makes 8 reads through the single table read
// port overlapped with the shared blend unit, then S_PUT delivers the
// result once the output register is free; the next item is taken in
// S_IDLE after that. A load runs through S_LOAD and S_WRITE. A finished
// result waits in the output register while the next item is taken.
// base_increment may be written whenever no item is in flight.
module stereo_wavetable_oscillator_unit #(
    parameter int NUM_WAVES   = 60,
    parameter int WAVE_LENGTH = 600
) (
    input logic          clk,
    input logic          rst_n,
    swo_cmd_if.sink      cmd,
    swo_result_if.source result,
    swo_cfg_if.sink      cfg
);
    import swo_pkg::*;

    localparam int DEPTH = NUM_WAVES * WAVE_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WI_W  = $clog2(NUM_WAVES);
    localparam int POS_W = $clog2(WAVE_LENGTH);
    localparam int WL_W  = $clog2(WAVE_LENGTH + 1);
    localparam int Y_W   = KNOB_W + WI_W;
    localparam int Q_W   = Y_W + 5;
    localparam int X_W   = Y_W + FRAC_W + 1;
    localparam int R_W   = 14;
    localparam int SP_W  = PHASE_W + WL_W;
    localparam int LA_W  = LOAD_WAVE_W + WL_W;
    localparam int BW_W  = WI_W + WL_W;

    localparam logic [WI_W-1:0]  LAST_WAVE = WI_W'(NUM_WAVES - 1);
    localparam logic [WI_W:0]    LAST_WAVE_X = (WI_W + 1)'(NUM_WAVES - 1);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(WAVE_LENGTH - 1);
    localparam logic [WL_W-1:0]  WL_C      = WL_W'(WAVE_LENGTH);
    localparam logic [R_W-1:0]   DIV_ONE   = R_W'(KNOB_MAX);
    localparam logic [R_W-1:0]   DIV_TWO   = R_W'(2 * KNOB_MAX);

    // run-phase schedule
    localparam logic [3:0] RD_LAST    = 4'd7;
    localparam logic [3:0] CAP_FIRST  = 4'd1;
    localparam logic [3:0] CAP_LAST   = 4'd8;
    localparam logic [3:0] BL_AF_AT   = 4'd3;
    localparam logic [3:0] BL_BF_AT   = 4'd5;
    localparam logic [3:0] BL_AR_AT   = 4'd7;
    localparam logic [3:0] BL_BR_AT   = 4'd9;
    localparam logic [3:0] BL_FWD_AT  = 4'd10;
    localparam logic [3:0] BL_REV_AT  = 4'd12;
    localparam logic [3:0] CAP_AF     = BL_AF_AT + 4'd2;
    localparam logic [3:0] CAP_BF     = BL_BF_AT + 4'd2;
    localparam logic [3:0] CAP_AR     = BL_AR_AT + 4'd2;
    localparam logic [3:0] CAP_BR     = BL_BR_AT + 4'd2;
    localparam logic [3:0] CAP_FWD    = BL_FWD_AT + 4'd2;
    localparam logic [3:0] RUN_LAST   = BL_REV_AT + 4'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_WRITE, S_T0, S_T1, S_T2, S_T3, S_RUN, S_PUT
    } state_t;

    // control
    state_t     state_reg;
    logic [3:0] cnt_reg;
    logic       out_valid_reg;
    phase_t     phase_reg;
    phase_t     base_inc_reg;

    // datapath
    knob_t                  pitch_reg;
    knob_t                  morph_reg;
    logic [LOAD_WAVE_W-1:0] ld_wave_reg;
    logic [LOAD_POS_W-1:0]  ld_pos_reg;
    sample_t                ld_val_reg;
    logic [AW-1:0]          ld_addr_reg;
    logic                   ld_ok_reg;
    logic [Y_W-1:0]         y_reg;
    logic [POS_W-1:0]       fi_reg;
    logic [FRAC_W-1:0]      ff_reg;
    logic [Q_W-1:0]         q0_reg;
    logic [R_W-1:0]         rem_reg;
    logic [POS_W-1:0]       fn_reg;
    logic [POS_W-1:0]       ri_reg;
    logic [POS_W-1:0]       rp_reg;
    weight_t                rf_reg;
    logic [WI_W-1:0]        w1_reg;
    logic [WI_W-1:0]        w2_reg;
    weight_t                wf_reg;
    logic [AW-1:0]          base1_reg;
    logic [AW-1:0]          base2_reg;
    sample_t                smp_reg [8];
    sample_t                bl_reg [4];
    sample_t                fwd_reg;
    sample_t                rev_reg;
    out_sample_t            out_fwd_reg;
    out_sample_t            out_rev_reg;

    // next values
    logic [AW-1:0]     ld_addr_next;
    logic              ld_ok_next;
    logic [Y_W-1:0]    y_next;
    logic [SP_W-1:0]   sp;
    logic [Q_W-1:0]    q0_next;
    logic [X_W-1:0]    rem_wide;
    logic [POS_W-1:0]  fn_next;
    logic [POS_W-1:0]  ri_next;
    logic [POS_W-1:0]  rp_next;
    logic [1:0]        corr;
    logic [Q_W-1:0]    wpos;
    logic [WI_W-1:0]   w1_next;
    logic [WI_W-1:0]   w2_next;
    logic [AW-1:0]     base1_next;
    logic [AW-1:0]     base2_next;
    logic [AW-1:0]     sel_base;
    logic [POS_W-1:0]  sel_pos;
    logic              put_ok;

    // table and arithmetic units
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    sample_t       mem_rdata;
    sample_t       bl_a;
    sample_t       bl_b;
    weight_t       bl_w;
    sample_t       bl_res;
    phase_t        inc;

    swo_wave_mem #(.DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ld_addr_reg),
        .wdata (ld_val_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    swo_blend u_blend (
        .clk (clk),
        .a   (bl_a),
        .b   (bl_b),
        .w   (bl_w),
        .res (bl_res)
    );

    swo_incr u_incr (
        .clk      (clk),
        .pitch    (pitch_reg),
        .base_inc (base_inc_reg),
        .inc      (inc)
    );

    assign cmd.ready          = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.forward_out = out_fwd_reg;
    assign result.reverse_out = out_rev_reg;

    assign put_ok = !out_valid_reg || result.ready;
    assign mem_we = (state_reg == S_WRITE) && ld_ok_reg;
    assign mem_re = (state_reg == S_RUN) && (cnt_reg <= RD_LAST);

    always_comb
    begin
        ld_addr_next = AW'({{WL_W{1'b0}}, ld_wave_reg} * {{LOAD_WAVE_W{1'b0}}, WL_C}
                          + LA_W'(ld_pos_reg));
        ld_ok_next   = (ld_wave_reg < NUM_WAVES) && (ld_pos_reg < WAVE_LENGTH);

        y_next = Y_W'(morph_reg) * Y_W'(NUM_WAVES - 1);
        sp     = {{WL_W{1'b0}}, phase_reg} * {{PHASE_W{1'b0}}, WL_C};

        // morph * (waves-1) * 2^16 / 4095 by reciprocal series plus correction
        q0_next  = Q_W'({y_reg, 4'b0}) + Q_W'(y_reg >> 8);
        rem_wide = X_W'({y_reg, {FRAC_W{1'b0}}}) - X_W'({q0_next, 12'b0}) + X_W'(q0_next);

        fn_next = (fi_reg == LAST_POS) ? '0 : fi_reg + 1'b1;
        ri_next = LAST_POS - fi_reg;
        rp_next = (ri_next == '0) ? LAST_POS : ri_next - 1'b1;

        if (rem_reg >= DIV_TWO)
        begin
            corr = 2'd2;
        end
        else if (rem_reg >= DIV_ONE)
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
        wpos = q0_reg + Q_W'(corr);
        if (wpos[Q_W-1:FRAC_W] >= LAST_WAVE_X)
        begin
            w1_next = LAST_WAVE;
        end
        else
        begin
            w1_next = wpos[FRAC_W +: WI_W];
        end
        w2_next = (w1_next == LAST_WAVE) ? '0 : w1_next + 1'b1;

        base1_next = AW'({{WL_W{1'b0}}, w1_reg} * BW_W'(WL_C));
        base2_next = AW'({{WL_W{1'b0}}, w2_reg} * BW_W'(WL_C));

        sel_base = cnt_reg[1] ? base2_reg : base1_reg;
        if (cnt_reg[2])
        begin
            sel_pos = cnt_reg[0] ? rp_reg : ri_reg;
        end
        else
        begin
            sel_pos = cnt_reg[0] ? fn_reg : fi_reg;
        end
        mem_raddr = sel_base + AW'(sel_pos);
    end

    always_comb
    begin
        unique case (cnt_reg)
            BL_AF_AT:
            begin
                bl_a = smp_reg[0];
                bl_b = smp_reg[1];
                bl_w = {1'b0, ff_reg};
            end
            BL_BF_AT:
            begin
                bl_a = smp_reg[2];
                bl_b = smp_reg[3];
                bl_w = {1'b0, ff_reg};
            end
            BL_AR_AT:
            begin
                bl_a = smp_reg[4];
                bl_b = smp_reg[5];
                bl_w = rf_reg;
            end
            BL_BR_AT:
            begin
                bl_a = smp_reg[6];
                bl_b = smp_reg[7];
                bl_w = rf_reg;
            end
            BL_FWD_AT:
            begin
                bl_a = bl_reg[0];
                bl_b = bl_reg[1];
                bl_w = wf_reg;
            end
            BL_REV_AT:
            begin
                bl_a = bl_reg[2];
                bl_b = bl_reg[3];
                bl_w = wf_reg;
            end
            default:
            begin
                bl_a = smp_reg[0];
                bl_b = smp_reg[1];
                bl_w = {1'b0, ff_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            base_inc_reg  <= BASE_INC_RESET;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                base_inc_reg <= cfg.base_increment;
            end
            if (result.valid && result.ready && state_reg != S_PUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        state_reg <= (cmd.mode == MODE_LOAD) ? S_LOAD : S_T0;
                    end
                end
                S_LOAD:  state_reg <= S_WRITE;
                S_WRITE: state_reg <= S_IDLE;
                S_T0:    state_reg <= S_T1;
                S_T1:    state_reg <= S_T2;
                S_T2:    state_reg <= S_T3;
                S_T3:
                begin
                    state_reg <= S_RUN;
                    cnt_reg   <= '0;
                end
                S_RUN:
                begin
                    if (cnt_reg == RUN_LAST)
                    begin
                        state_reg <= S_PUT;
                        phase_reg <= phase_reg + inc;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PUT:
                begin
                    if (put_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    pitch_reg   <= cmd.pitch_knob;
                    morph_reg   <= cmd.morph_knob;
                    ld_wave_reg <= cmd.load_wave;
                    ld_pos_reg  <= cmd.load_position;
                    ld_val_reg  <= cmd.load_value;
                end
            end
            S_LOAD:
            begin
                ld_addr_reg <= ld_addr_next;
                ld_ok_reg   <= ld_ok_next;
            end
            S_T0:
            begin
                y_reg  <= y_next;
                fi_reg <= sp[PHASE_W +: POS_W];
                ff_reg <= sp[PHASE_W-1:FRAC_W];
            end
            S_T1:
            begin
                q0_reg  <= q0_next;
                rem_reg <= rem_wide[R_W-1:0];
                fn_reg  <= fn_next;
                ri_reg  <= ri_next;
                rp_reg  <= rp_next;
                rf_reg  <= WEIGHT_ONE - {1'b0, ff_reg};
            end
            S_T2:
            begin
                w1_reg <= w1_next;
                w2_reg <= w2_next;
                wf_reg <= {1'b0, wpos[FRAC_W-1:0]};
            end
            S_T3:
            begin
                base1_reg <= base1_next;
                base2_reg <= base2_next;
            end
            S_RUN:
            begin
                if (cnt_reg >= CAP_FIRST && cnt_reg <= CAP_LAST)
                begin
                    smp_reg[3'(cnt_reg - CAP_FIRST)] <= mem_rdata;
                end
                if (cnt_reg == CAP_AF)
                begin
                    bl_reg[0] <= bl_res;
                end
                if (cnt_reg == CAP_BF)
                begin
                    bl_reg[1] <= bl_res;
                end
                if (cnt_reg == CAP_AR)
                begin
                    bl_reg[2] <= bl_res;
                end
                if (cnt_reg == CAP_BR)
                begin
                    bl_reg[3] <= bl_res;
                end
                if (cnt_reg == CAP_FWD)
                begin
                    fwd_reg <= bl_res;
                end
                if (cnt_reg == RUN_LAST)
                begin
                    rev_reg <= bl_res;
                end
            end
            S_PUT:
            begin
                if (put_ok)
                begin
                    out_fwd_reg <= fwd_reg[SAMPLE_W-1 -: OUT_W];
                    out_rev_reg <= rev_reg[SAMPLE_W-1 -: OUT_W];
                end
            end
            default: ;
        endcase
    end

    // a result only appears out of the delivery step
    a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == S_PUT))
        else $error("result valid rose outside delivery");

    // table is never written and read in the same cycle
    a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table written and read together");

    // phase only moves at the end of a tick
    a_phase_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_reg) |-> $past(state_reg == S_RUN && cnt_reg == RUN_LAST))
        else $error("phase changed outside tick end");

    // a pending result that is not taken holds delivery back
    a_put_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT && out_valid_reg && !result.ready) |=> (state_reg == S_PUT))
        else $error("pending result overwritten");

endmodule
